[design/mcts_pkg.sv]
// Package for the music command tone sequencer.
// Holds command and articulation codes, state encoding, widths and the pitch table.
// No dependencies.
package mcts_pkg;

    typedef enum logic [2:0] {
        OP_NOTE   = 3'd0,
        OP_PAUSE  = 3'd1,
        OP_TEMPO  = 3'd2,
        OP_LENGTH = 3'd3,
        OP_OCTAVE = 3'd4,
        OP_ARTIC  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ART_NORMAL   = 2'd0,
        ART_LEGATO   = 2'd1,
        ART_STACCATO = 2'd2
    } art_t;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DIV1_GO   = 7'b0000010,
        S_DIV1_WAIT = 7'b0000100,
        S_EMIT1     = 7'b0001000,
        S_DIV2_GO   = 7'b0010000,
        S_DIV2_WAIT = 7'b0100000,
        S_EMIT2     = 7'b1000000
    } state_t;

    localparam int DIV_DW   = 30;   // dividend / quotient width
    localparam int DIV_VW   = 26;   // divisor width
    localparam int DIV_CW   = 5;    // iteration counter width
    localparam int FREQ_W   = 19;
    localparam int DUR_W    = 22;
    localparam int TOTAL_W  = 40;
    localparam int LEN_W    = 15;
    localparam int TEMPO_W  = 8;
    localparam int PROD_W   = LEN_W + TEMPO_W;
    localparam int NUM_W    = 27;

    localparam logic [NUM_W-1:0]   NUM_PLAIN  = 27'd60000000;
    localparam logic [NUM_W-1:0]   NUM_DOTTED = 27'd90000000;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN  = 8'd32;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX  = 8'd255;
    localparam logic [TEMPO_W-1:0] TEMPO_RST  = 8'd120;
    localparam logic [LEN_W-1:0]   LENGTH_RST = 15'd4;
    localparam logic [2:0]         OCTAVE_MAX = 3'd6;

    // dividend multipliers over a divisor of 8*length*tempo
    localparam logic [3:0] K_WHOLE     = 4'd8;
    localparam logic [3:0] K_NORM_TONE = 4'd7;
    localparam logic [3:0] K_STAC_TONE = 4'd6;
    localparam logic [1:0] K_NORM_REST = 2'd1;
    localparam logic [1:0] K_STAC_REST = 2'd2;

    // centihertz at octave 3; sharp wins over flat; letter 7 is silence
    function automatic logic [15:0] pitch_base(input logic [2:0] letter,
                                               input logic [1:0] acc);
        logic [15:0] nat;
        logic [15:0] shp;
        logic [15:0] flt;
        nat = 16'd0;
        shp = 16'd0;
        flt = 16'd0;
        unique case (letter)
            3'd0: begin nat = 16'd44000; shp = 16'd46616; flt = 16'd41530; end
            3'd1: begin nat = 16'd49388; shp = 16'd26163; flt = 16'd46616; end
            3'd2: begin nat = 16'd26163; shp = 16'd27718; flt = 16'd49388; end
            3'd3: begin nat = 16'd29366; shp = 16'd31113; flt = 16'd27718; end
            3'd4: begin nat = 16'd32963; shp = 16'd34923; flt = 16'd31113; end
            3'd5: begin nat = 16'd34923; shp = 16'd36999; flt = 16'd32963; end
            3'd6: begin nat = 16'd39200; shp = 16'd41530; flt = 16'd36999; end
            default: begin nat = 16'd0; shp = 16'd0; flt = 16'd0; end
        endcase
        if (acc[0])
            return shp;
        else if (acc[1])
            return flt;
        else
            return nat;
    endfunction

endpackage

[design/mcts_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on mcts_pkg for widths.
module mcts_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mcts_pkg::DIV_DW-1:0]  dividend,
    input  logic [mcts_pkg::DIV_VW-1:0]  divisor,
    output logic                         done,
    output logic [mcts_pkg::DIV_DW-1:0]  quotient
);
    import mcts_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [DIV_VW-1:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0]   quo_reg, quo_next;
    logic [DIV_VW-1:0]   dvs_reg, dvs_next;
    logic [DIV_VW:0]     shifted;
    logic [DIV_VW:0]     diff;

    assign shifted = {rem_reg, quo_reg[DIV_DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_VW])
            begin
                rem_next = diff[DIV_VW-1:0];
                quo_next = {quo_reg[DIV_DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_VW-1:0];
                quo_next = {quo_reg[DIV_DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/music_command_tone_sequencer.sv]
// Music command tone sequencer: turns parsed music commands into tone beats.
// Depends on mcts_pkg and mcts_div.
//
// Usage:
//   Command channel (cmd_valid / cmd_stall): one command per beat. Setting
//   commands (tempo, length, octave, articulation) take effect in the cycle
//   they are taken and produce no output. Notes and pauses hold cmd_stall
//   high until all their tone beats have been loaded into the output register.
//   Tone channel (tone_valid / tone_stall): each beat carries frequency
//   (0 = silence), duration, running total and a last flag. A note makes two
//   beats (tone then silence) except under legato; a pause makes one.
//   Timing: every beat needs one pass of the serial divider; the sequencer
//   starts the divider, waits for its done strobe and then loads the beat
//   into the output register once that register is free. A finished beat
//   waits in the output register while tone_stall is high; the next command
//   may be taken meanwhile.
//   Reset: octave 0, length 4, tempo 120, normal articulation, total 0,
//   no beat pending. Stalls only delay; nothing is dropped or repeated.
module music_command_tone_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [2:0]                     operation,
    input  logic [2:0]                     note_letter,
    input  logic [1:0]                     accidental,
    input  logic                           dotted,
    input  logic signed [15:0]             amount,
    input  logic [1:0]                     articulation_mode,
    output logic                           tone_valid,
    input  logic                           tone_stall,
    output logic [mcts_pkg::FREQ_W-1:0]    frequency_centihertz,
    output logic [mcts_pkg::DUR_W-1:0]     duration_us,
    output logic [mcts_pkg::TOTAL_W-1:0]   total_us,
    output logic                           last
);
    import mcts_pkg::*;

    state_t               state_reg, state_next;
    logic [2:0]           octave_reg, octave_next;
    logic [LEN_W-1:0]     length_reg, length_next;
    logic [TEMPO_W-1:0]   tempo_reg, tempo_next;
    art_t                 art_reg, art_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 tone_valid_reg, tone_valid_next;

    logic [PROD_W-1:0]    d_reg, d_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic                 two_reg, two_next;
    logic [3:0]           k1_reg, k1_next;
    logic [1:0]           k2_reg, k2_next;
    logic [FREQ_W-1:0]    ofreq_reg, ofreq_next;
    logic [DUR_W-1:0]     odur_reg, odur_next;
    logic                 olast_reg, olast_next;

    logic                 cmd_take;
    logic                 out_free;
    logic                 load;
    logic [FREQ_W-1:0]    load_freq;
    logic                 load_last;
    logic [LEN_W-1:0]     pause_len;
    logic [LEN_W-1:0]     mul_a;
    logic [21:0]          pitch_shift;
    logic [3:0]           k_sel;
    logic                 div_start;
    logic [DIV_DW-1:0]    div_dividend;
    logic [DIV_VW-1:0]    div_divisor;
    logic                 div_done;
    logic [DIV_DW-1:0]    div_quotient;
    logic [TOTAL_W:0]     total_sum;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && (state_reg == S_IDLE);
    assign out_free  = !tone_valid_reg || !tone_stall;

    assign pause_len   = (amount < 16'sd1) ? LEN_W'(1) : amount[LEN_W-1:0];
    assign mul_a       = (operation == OP_PAUSE) ? pause_len : length_reg;
    assign pitch_shift = 22'(pitch_base(note_letter, accidental)) << octave_reg;

    assign div_start    = (state_reg == S_DIV1_GO) || (state_reg == S_DIV2_GO);
    assign k_sel        = (state_reg == S_DIV1_GO) ? k1_reg : {2'b00, k2_reg};
    assign div_dividend = DIV_DW'(num_reg) * DIV_DW'(k_sel);
    assign div_divisor  = {d_reg, 3'b000};

    mcts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign load      = out_free &&
                       ((state_reg == S_EMIT1) || (state_reg == S_EMIT2));
    assign load_freq = (state_reg == S_EMIT1) ? freq_reg : '0;
    assign load_last = (state_reg == S_EMIT2) || !two_reg;
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(div_quotient[DUR_W-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        octave_next = octave_reg;
        length_next = length_reg;
        tempo_next  = tempo_reg;
        art_next    = art_reg;
        total_next  = total_reg;
        d_next      = d_reg;
        num_next    = num_reg;
        freq_next   = freq_reg;
        two_next    = two_reg;
        k1_next     = k1_reg;
        k2_next     = k2_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    d_next   = PROD_W'(mul_a) * PROD_W'(tempo_reg);
                    num_next = dotted ? NUM_DOTTED : NUM_PLAIN;
                    unique case (operation)
                        OP_NOTE:
                        begin
                            freq_next  = pitch_shift[21:3];
                            state_next = S_DIV1_GO;
                            unique case (art_reg)
                                ART_LEGATO:
                                begin
                                    two_next = 1'b0;
                                    k1_next  = K_WHOLE;
                                    k2_next  = K_NORM_REST;
                                end
                                ART_STACCATO:
                                begin
                                    two_next = 1'b1;
                                    k1_next  = K_STAC_TONE;
                                    k2_next  = K_STAC_REST;
                                end
                                default:
                                begin
                                    two_next = 1'b1;
                                    k1_next  = K_NORM_TONE;
                                    k2_next  = K_NORM_REST;
                                end
                            endcase
                        end
                        OP_PAUSE:
                        begin
                            freq_next  = '0;
                            two_next   = 1'b0;
                            k1_next    = K_WHOLE;
                            state_next = S_DIV1_GO;
                        end
                        OP_TEMPO:
                        begin
                            if (amount < 16'sd32)
                                tempo_next = TEMPO_MIN;
                            else if (amount > 16'sd255)
                                tempo_next = TEMPO_MAX;
                            else
                                tempo_next = amount[TEMPO_W-1:0];
                        end
                        OP_LENGTH:
                        begin
                            length_next = pause_len;
                        end
                        OP_OCTAVE:
                        begin
                            if (amount < 16'sd0)
                                octave_next = '0;
                            else if (amount > 16'sd6)
                                octave_next = OCTAVE_MAX;
                            else
                                octave_next = amount[2:0];
                        end
                        OP_ARTIC:
                        begin
                            unique case (articulation_mode)
                                ART_NORMAL, ART_LEGATO, ART_STACCATO:
                                    art_next = art_t'(articulation_mode);
                                default:
                                    art_next = art_reg;
                            endcase
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV1_GO:
                state_next = S_DIV1_WAIT;
            S_DIV1_WAIT:
                if (div_done)
                    state_next = S_EMIT1;
            S_EMIT1:
                if (load)
                    state_next = two_reg ? S_DIV2_GO : S_IDLE;
            S_DIV2_GO:
                state_next = S_DIV2_WAIT;
            S_DIV2_WAIT:
                if (div_done)
                    state_next = S_EMIT2;
            S_EMIT2:
                if (load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase

        if (load)
            total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    end

    always_comb
    begin
        tone_valid_next = tone_valid_reg;
        ofreq_next      = ofreq_reg;
        odur_next       = odur_reg;
        olast_next      = olast_reg;
        if (load)
        begin
            tone_valid_next = 1'b1;
            ofreq_next      = load_freq;
            odur_next       = div_quotient[DUR_W-1:0];
            olast_next      = load_last;
        end
        else if (!tone_stall)
        begin
            tone_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            octave_reg     <= '0;
            length_reg     <= LENGTH_RST;
            tempo_reg      <= TEMPO_RST;
            art_reg        <= ART_NORMAL;
            total_reg      <= '0;
            tone_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            octave_reg     <= octave_next;
            length_reg     <= length_next;
            tempo_reg      <= tempo_next;
            art_reg        <= art_next;
            total_reg      <= total_next;
            tone_valid_reg <= tone_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        num_reg   <= num_next;
        freq_reg  <= freq_next;
        two_reg   <= two_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        ofreq_reg <= ofreq_next;
        odur_reg  <= odur_next;
        olast_reg <= olast_next;
    end

    assign tone_valid           = tone_valid_reg;
    assign frequency_centihertz = ofreq_reg;
    assign duration_us          = odur_reg;
    assign total_us             = total_reg;
    assign last                 = olast_reg;

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("running total decreased");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV1_WAIT || state_reg == S_DIV2_WAIT))
        else $error("divider finished outside a wait state");

    a_first_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (tone_valid_reg && !olast_reg) |-> cmd_stall)
        else $error("command taken while a note's second beat is owed");

endmodule

[tb/music_command_tone_sequencer_test.sv]
// Self-checking testbench for music_command_tone_sequencer: directed and random command streams.
// An in-bench tone predictor checks every beat; random runs use four pacings of both handshakes.
// Depends on mcts_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module music_command_tone_sequencer_test;

    import mcts_pkg::*;

    localparam logic [2:0] OP_UNUSED6  = 3'd6;
    localparam logic [2:0] OP_UNUSED7  = 3'd7;
    localparam logic [1:0] ART_UNUSED  = 2'd3;

    localparam logic [2:0] LETTER_A    = 3'd0;
    localparam logic [2:0] LETTER_B    = 3'd1;
    localparam logic [2:0] LETTER_C    = 3'd2;
    localparam logic [2:0] LETTER_D    = 3'd3;
    localparam logic [2:0] LETTER_E    = 3'd4;
    localparam logic [2:0] LETTER_F    = 3'd5;
    localparam logic [2:0] LETTER_G    = 3'd6;
    localparam logic [2:0] LETTER_REST = 3'd7;

    localparam logic [1:0] ACC_NATURAL = 2'd0;
    localparam logic [1:0] ACC_SHARP   = 2'd1;
    localparam logic [1:0] ACC_FLAT    = 2'd2;
    localparam logic [1:0] ACC_BOTH    = 2'd3;

    localparam longint unsigned BEAT_NUM       = 64'd60000000;
    localparam longint unsigned BEAT_NUM_DOT   = 64'd90000000;
    localparam logic [39:0]     TOTAL_SAT      = 40'hFF_FFFF_FFFF;
    localparam int              LIMIT_CYCLES   = 1000000;
    localparam int              TAIL_CYCLES    = 100;
    localparam int              MAX_REPORTS    = 40;

    typedef struct packed {
        logic [FREQ_W-1:0]  freq;
        logic [DUR_W-1:0]   dur;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } tone_beat_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    logic [2:0]           operation = 3'd0;
    logic [2:0]           note_letter = 3'd0;
    logic [1:0]           accidental = 2'd0;
    logic                 dotted = 1'b0;
    logic signed [15:0]   amount = 16'sd0;
    logic [1:0]           articulation_mode = 2'd0;
    logic                 tone_valid;
    logic                 tone_stall = 1'b0;
    logic [FREQ_W-1:0]    frequency_centihertz;
    logic [DUR_W-1:0]     duration_us;
    logic [TOTAL_W-1:0]   total_us;
    logic                 last;

    // predictor state
    logic [2:0]           octave_q;
    logic [15:0]          length_q;
    logic [7:0]           tempo_q;
    logic [1:0]           artic_q;
    logic [39:0]          total_q;

    tone_beat_t           expected_tones[$];
    tone_beat_t           want;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    int                   errors = 0;
    int                   commands_sent = 0;
    int                   beats_checked = 0;
    int                   cycles = 0;

    music_command_tone_sequencer u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd_valid            (cmd_valid),
        .cmd_stall            (cmd_stall),
        .operation            (operation),
        .note_letter          (note_letter),
        .accidental           (accidental),
        .dotted               (dotted),
        .amount               (amount),
        .articulation_mode    (articulation_mode),
        .tone_valid           (tone_valid),
        .tone_stall           (tone_stall),
        .frequency_centihertz (frequency_centihertz),
        .duration_us          (duration_us),
        .total_us             (total_us),
        .last                 (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned base_pitch(input logic [2:0] letter,
                                                   input logic [1:0] sel);
        longint unsigned nat;
        longint unsigned shp;
        longint unsigned flt;
        case (letter)
            LETTER_A: begin nat = 44000; shp = 46616; flt = 41530; end
            LETTER_B: begin nat = 49388; shp = 26163; flt = 46616; end
            LETTER_C: begin nat = 26163; shp = 27718; flt = 49388; end
            LETTER_D: begin nat = 29366; shp = 31113; flt = 27718; end
            LETTER_E: begin nat = 32963; shp = 34923; flt = 31113; end
            LETTER_F: begin nat = 34923; shp = 36999; flt = 32963; end
            LETTER_G: begin nat = 39200; shp = 41530; flt = 36999; end
            default:  begin nat = 0;     shp = 0;     flt = 0;     end
        endcase
        if (sel == ACC_SHARP)
            return shp;
        else if (sel == ACC_FLAT)
            return flt;
        else
            return nat;
    endfunction

    task automatic push_beat(input longint unsigned freq, input longint unsigned dur,
                             input logic lst);
        logic [40:0] sum;
        tone_beat_t  b;
        sum = {1'b0, total_q} + 41'(dur);
        total_q = sum[40] ? TOTAL_SAT : sum[39:0];
        b.freq  = freq[FREQ_W-1:0];
        b.dur   = dur[DUR_W-1:0];
        b.total = total_q;
        b.last  = lst;
        expected_tones.push_back(b);
    endtask

    task automatic predict_command(input logic [2:0] op, input logic [2:0] letter,
                                   input logic [1:0] acc, input logic dot,
                                   input logic signed [15:0] amt, input logic [1:0] mode);
        int              a;
        longint unsigned num;
        longint unsigned d;
        longint unsigned freq;
        logic [1:0]      sel;
        a = amt;
        num = dot ? BEAT_NUM_DOT : BEAT_NUM;
        case (op)
            OP_NOTE:
            begin
                freq = 0;
                if (letter != LETTER_REST)
                begin
                    sel = acc[0] ? ACC_SHARP : (acc[1] ? ACC_FLAT : ACC_NATURAL);
                    freq = (base_pitch(letter, sel) << octave_q) >> 3;
                end
                d = 64'(length_q) * 64'(tempo_q);
                if (artic_q == ART_LEGATO)
                    push_beat(freq, num / d, 1'b1);
                else if (artic_q == ART_STACCATO)
                begin
                    push_beat(freq, (num * 3) / (4 * d), 1'b0);
                    push_beat(0, num / (4 * d), 1'b1);
                end
                else
                begin
                    push_beat(freq, (num * 7) / (8 * d), 1'b0);
                    push_beat(0, num / (8 * d), 1'b1);
                end
            end
            OP_PAUSE:
            begin
                d = 64'((a < 1) ? 1 : a) * 64'(tempo_q);
                push_beat(0, num / d, 1'b1);
            end
            OP_TEMPO:
                tempo_q = (a < 32) ? 8'd32 : ((a > 255) ? 8'd255 : 8'(a));
            OP_LENGTH:
                length_q = (a < 1) ? 16'd1 : 16'(a);
            OP_OCTAVE:
                octave_q = (a < 0) ? 3'd0 : ((a > 6) ? 3'd6 : 3'(a));
            OP_ARTIC:
                if (mode != ART_UNUSED)
                    artic_q = mode;
            default: ;
        endcase
    endtask

    task automatic issue_command(input logic [2:0] op, input logic [2:0] letter,
                                 input logic [1:0] acc, input logic dot,
                                 input logic signed [15:0] amt, input logic [1:0] mode);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid         <= 1'b1;
        operation         <= op;
        note_letter       <= letter;
        accidental        <= acc;
        dotted            <= dot;
        amount            <= amt;
        articulation_mode <= mode;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_command(op, letter, acc, dot, amt, mode);
        commands_sent++;
    endtask

    task automatic drain_tones();
        cmd_valid <= 1'b0;
        while (expected_tones.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string field, input longint unsigned exp_v,
                                   input longint unsigned got_v);
        if (errors < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && tone_valid && !tone_stall)
        begin
            if (expected_tones.size() == 0)
            begin
                report_mismatch("unexpected beat, frequency", 0, 64'(frequency_centihertz));
            end
            else
            begin
                want = expected_tones.pop_front();
                beats_checked++;
                if (frequency_centihertz !== want.freq)
                    report_mismatch("frequency_centihertz", 64'(want.freq),
                                    64'(frequency_centihertz));
                if (duration_us !== want.dur)
                    report_mismatch("duration_us", 64'(want.dur), 64'(duration_us));
                if (total_us !== want.total)
                    report_mismatch("total_us", 64'(want.total), 64'(total_us));
                if (last !== want.last)
                    report_mismatch("last", 64'(want.last), 64'(last));
            end
        end
        tone_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d beats outstanding", $time, expected_tones.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_reset_values();
        issue_command(OP_NOTE, LETTER_A, ACC_NATURAL, 1'b0, 16'sd0, ART_NORMAL);
        drain_tones();
    endtask

    task automatic test_pitch_and_octave();
        issue_command(OP_OCTAVE, LETTER_A, ACC_NATURAL, 1'b0, 16'sh7FFF, ART_NORMAL);
        issue_command(OP_NOTE, LETTER_B, ACC_SHARP, 1'b1, 16'sd0, ART_NORMAL);
        issue_command(OP_OCTAVE, LETTER_A, ACC_NATURAL, 1'b0, 16'sh8000, ART_NORMAL);
        issue_command(OP_NOTE, LETTER_REST, ACC_FLAT, 1'b0, 16'sd0, ART_NORMAL);
        // both accidental bits: sharp wins
        issue_command(OP_NOTE, LETTER_D, ACC_BOTH, 1'b0, 16'sd0, ART_NORMAL);
        drain_tones();
    endtask

    task automatic test_timing_extremes();
        issue_command(OP_TEMPO, LETTER_A, ACC_NATURAL, 1'b0, 16'sh8000, ART_NORMAL);
        issue_command(OP_LENGTH, LETTER_A, ACC_NATURAL, 1'b0, 16'sd1, ART_NORMAL);
        issue_command(OP_ARTIC, LETTER_A, ACC_NATURAL, 1'b0, 16'sd0, ART_LEGATO);
        issue_command(OP_NOTE, LETTER_C, ACC_FLAT, 1'b1, 16'sd0, ART_NORMAL);
        issue_command(OP_TEMPO, LETTER_A, ACC_NATURAL, 1'b0, 16'sh7FFF, ART_NORMAL);
        issue_command(OP_LENGTH, LETTER_A, ACC_NATURAL, 1'b0, 16'sh7FFF, ART_NORMAL);
        issue_command(OP_ARTIC, LETTER_A, ACC_NATURAL, 1'b0, 16'sd0, ART_STACCATO);
        // short pieces: durations truncate to whole microseconds
        issue_command(OP_NOTE, LETTER_G, ACC_NATURAL, 1'b0, 16'sd0, ART_NORMAL);
        issue_command(OP_LENGTH, LETTER_A, ACC_NATURAL, 1'b0, 16'sh8000, ART_NORMAL);
        issue_command(OP_NOTE, LETTER_E, ACC_NATURAL, 1'b1, 16'sd0, ART_NORMAL);
        drain_tones();
    endtask

    task automatic test_pause();
        issue_command(OP_PAUSE, LETTER_A, ACC_NATURAL, 1'b1, 16'sd0, ART_NORMAL);
        issue_command(OP_PAUSE, LETTER_A, ACC_NATURAL, 1'b0, -16'sd1, ART_NORMAL);
        issue_command(OP_PAUSE, LETTER_A, ACC_NATURAL, 1'b0, 16'sh7FFF, ART_NORMAL);
        drain_tones();
    endtask

    task automatic test_ignored_codes();
        issue_command(OP_ARTIC, LETTER_A, ACC_NATURAL, 1'b0, 16'sd0, ART_UNUSED);
        issue_command(OP_NOTE, LETTER_F, ACC_SHARP, 1'b0, 16'sd0, ART_NORMAL);
        issue_command(OP_UNUSED6, LETTER_G, ACC_BOTH, 1'b1, 16'sh5A5A, ART_LEGATO);
        issue_command(OP_UNUSED7, LETTER_REST, ACC_FLAT, 1'b1, 16'shA5A5, ART_UNUSED);
        issue_command(OP_ARTIC, LETTER_A, ACC_NATURAL, 1'b0, 16'sd0, ART_NORMAL);
        drain_tones();
    endtask

    task automatic test_random(input int send_pct, input int stall_chance, input int n);
        int                 counted;
        int                 r;
        logic [2:0]         op;
        logic [2:0]         letter;
        logic [1:0]         acc;
        logic               dot;
        logic signed [15:0] amt;
        logic [1:0]         mode;
        send_idle_pct = send_pct;
        stall_pct = stall_chance;
        counted = 0;
        while (counted < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                op = OP_NOTE;
            else if (r < 60)
                op = OP_PAUSE;
            else if (r < 70)
                op = OP_TEMPO;
            else if (r < 80)
                op = OP_LENGTH;
            else if (r < 88)
                op = OP_OCTAVE;
            else if (r < 95)
                op = OP_ARTIC;
            else if (r < 98)
                op = OP_UNUSED6;
            else
                op = OP_UNUSED7;
            letter = 3'($urandom_range(0, 7));
            acc    = 2'($urandom_range(0, 3));
            dot    = 1'($urandom_range(0, 1));
            mode   = 2'($urandom_range(0, 3));
            amt    = 16'($urandom);
            r = $urandom_range(0, 99);
            case (op)
                OP_TEMPO:
                    if (r < 70)
                        amt = 16'($urandom_range(32, 255));
                    else if (r < 85)
                        amt = 16'($urandom_range(0, 300));
                OP_LENGTH, OP_PAUSE:
                    if (r < 65)
                        amt = 16'($urandom_range(1, 16));
                    else if (r < 85)
                        amt = 16'(int'($urandom_range(0, 64)) - 8);
                OP_OCTAVE:
                    if (r < 80)
                        amt = 16'(int'($urandom_range(0, 10)) - 2);
                default: ;
            endcase
            issue_command(op, letter, acc, dot, amt, mode);
            if (!(op == OP_UNUSED6 || op == OP_UNUSED7 ||
                  (op == OP_ARTIC && mode == ART_UNUSED)))
                counted++;
        end
        drain_tones();
    endtask

    initial
    begin
        octave_q = 3'd0;
        length_q = 16'd4;
        tempo_q  = 8'd120;
        artic_q  = ART_NORMAL;
        total_q  = 40'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_pitch_and_octave();
        test_timing_extremes();
        test_pause();
        test_ignored_codes();
        test_random(0, 0, 175);
        test_random(71, 0, 175);
        test_random(0, 71, 175);
        test_random(26, 26, 175);
        $display("Checked %0d tone beats from %0d commands, %0d errors", beats_checked,
                 commands_sent, errors);
        $display("Covered pitches, clamps, articulations, pauses, ignored codes, four pacings");
        if (errors == 0 && expected_tones.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
design/mcts_pkg.sv
design/mcts_div.sv
design/music_command_tone_sequencer.sv
tb/music_command_tone_sequencer_test.sv
